>>> rtl/synth_control_tick_defines.svh
// ----------------------------------------------------------------------------
// synth_control_tick_defines.svh
// Assertion macros shared by the synth control tick RTL.
// ----------------------------------------------------------------------------
`ifndef SYNTH_CONTROL_TICK_DEFINES_SVH
`define SYNTH_CONTROL_TICK_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sct assertion failed");

// Next-cycle implication, checked outside reset.
`define SCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sct assertion failed");

`endif

>>> rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Transaction types and fixed constants of the synth control tick block.
// ----------------------------------------------------------------------------
package sct_pkg;

    typedef struct packed {
        logic [15:0] target_increment;
        logic [15:0] glide_step;
        logic        key_pressed;
        logic        note_active;
        logic [9:0]  decay_step;
    } item_t;

    typedef struct packed {
        logic [15:0] pitch_increment;
        logic [11:0] cutoff_cv;
        logic [15:0] pwm_level;
    } result_t;

    localparam logic [15:0] ENV_FULL   = 16'd32768;
    localparam logic [15:0] PWM_STEP   = 16'd64;
    localparam logic [15:0] PWM_TOP    = 16'd63488;
    localparam logic [15:0] PWM_BOTTOM = 16'd2048;
    localparam int unsigned CV_SHIFT   = 4;

endpackage

>>> rtl/sct_core.sv
// ----------------------------------------------------------------------------
// sct_core
// Voice state registers and the per-tick update: glide, envelope, PWM sweep.
// ----------------------------------------------------------------------------
module sct_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  sct_pkg::item_t  item,
    output sct_pkg::result_t result
);

    logic [15:0] incr_reg;
    logic [15:0] incr_next;
    logic [15:0] env_reg;
    logic [15:0] env_next;
    logic [15:0] pwm_reg;
    logic [15:0] pwm_next;
    logic        falling_reg;
    logic        falling_next;

    always_comb
    begin
        logic [15:0] gap;
        logic [15:0] env_base;
        logic [15:0] decay;
        logic [15:0] shifted;

        incr_next = incr_reg;
        if (incr_reg < item.target_increment)
        begin
            gap       = item.target_increment - incr_reg;
            incr_next = (gap > item.glide_step) ? incr_reg + item.glide_step
                                                : item.target_increment;
        end
        else if (incr_reg > item.target_increment)
        begin
            gap       = incr_reg - item.target_increment;
            incr_next = (gap > item.glide_step) ? incr_reg - item.glide_step
                                                : item.target_increment;
        end
        else
        begin
            gap = 16'd0;
        end

        env_base = item.key_pressed ? sct_pkg::ENV_FULL : env_reg;
        decay    = {6'd0, item.decay_step};
        env_next = (env_base > decay) ? env_base - decay : 16'd0;

        pwm_next     = pwm_reg;
        falling_next = falling_reg;
        if (item.note_active)
        begin
            if (!falling_reg)
            begin
                pwm_next     = pwm_reg + sct_pkg::PWM_STEP;
                falling_next = pwm_next > sct_pkg::PWM_TOP;
            end
            else
            begin
                pwm_next     = pwm_reg - sct_pkg::PWM_STEP;
                falling_next = pwm_next > sct_pkg::PWM_BOTTOM;
            end
        end

        shifted                = env_next >> sct_pkg::CV_SHIFT;
        result.pitch_increment = incr_next;
        result.cutoff_cv       = shifted[11:0];
        result.pwm_level       = pwm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            incr_reg    <= 16'd0;
            env_reg     <= sct_pkg::ENV_FULL;
            pwm_reg     <= 16'd0;
            falling_reg <= 1'b0;
        end
        else if (advance)
        begin
            incr_reg    <= incr_next;
            env_reg     <= env_next;
            pwm_reg     <= pwm_next;
            falling_reg <= falling_next;
        end
    end

endmodule

>>> rtl/synth_control_tick.sv
// ----------------------------------------------------------------------------
// synth_control_tick
// Per-tick control update of one synthesizer voice.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : one control tick per transaction (target pitch, glide
//                    rate, key press, note on, decay step); valid/stall.
//   result channel : one transaction per tick with the slewed pitch
//                    increment, the envelope as a 12-bit DAC value and the
//                    PWM level; valid/stall.
//   Path: a tick accepted into the input register moves on to the result
//   register.
//   Throughput: one tick per cycle unless the result stalls; the voice state
//   updates as the tick moves from the input register to the result register.
//   Reset: pitch 0, envelope full (32768), PWM 0 sweeping upward, both
//   registers empty.
//   Stall: a stalled result holds; the input register keeps taking a tick
//   until it is full, then item_stall rises in the same cycle.
// ----------------------------------------------------------------------------
`include "synth_control_tick_defines.svh"

module synth_control_tick (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  sct_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output sct_pkg::result_t result
);

    logic             item_valid_reg;
    sct_pkg::item_t   item_reg;
    logic             result_valid_reg;
    sct_pkg::result_t result_reg;
    sct_pkg::result_t result_next;
    logic             out_free;
    logic             advance;

    assign out_free   = !result_valid_reg || !result_stall;
    assign advance    = item_valid_reg && out_free;
    assign item_stall = item_valid_reg && !out_free;

    sct_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .result  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
            begin
                item_valid_reg <= item_valid;
            end
            if (out_free)
            begin
                result_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `SCT_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, item_stall, item_valid_reg)
    `SCT_ASSERT_NEXT(a_tick_reaches_result, clk, rst_n,
                     item_valid_reg && !result_valid_reg, result_valid_reg)
    `SCT_ASSERT_NEXT(a_result_drains, clk, rst_n,
                     result_valid_reg && !result_stall && !item_valid_reg, !result_valid_reg)
    `SCT_ASSERT_SAME(a_cutoff_range, clk, rst_n,
                     result_valid_reg, result_reg.cutoff_cv <= 12'd2048)

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for synth_control_tick
// Drives control ticks through the valid/stall item channel and checks every
// result transaction against an in-bench voice model (glide, envelope, PWM
// triangle). Directed corner ticks come first, then random note phrases with
// noise, under three idle/stall mixes with two long result hold-offs.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PHRASE_TICKS = 479;
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 48;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    sct_pkg::item_t   tick_in = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    sct_pkg::result_t tick_out;

    sct_pkg::item_t   pending_ticks[$];
    sct_pkg::result_t expected_ticks[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int results_seen = 0;
    int hold_left = 0;
    int last_hold_mark = -1;
    int quiet_cycles = 0;

    // voice state of the model
    logic [15:0] pitch_now;
    logic [15:0] env_now;
    logic [15:0] pwm_now;
    logic        pwm_down;

    synth_control_tick dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (tick_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (tick_out)
    );

    always #6 clk = ~clk;

    function automatic sct_pkg::result_t advance_voice(input sct_pkg::item_t t);
        sct_pkg::result_t r;
        logic [15:0]      gap;
        if (pitch_now < t.target_increment)
        begin
            gap = t.target_increment - pitch_now;
            pitch_now = (gap > t.glide_step) ? pitch_now + t.glide_step : t.target_increment;
        end
        else if (pitch_now > t.target_increment)
        begin
            gap = pitch_now - t.target_increment;
            pitch_now = (gap > t.glide_step) ? pitch_now - t.glide_step : t.target_increment;
        end
        if (t.key_pressed)
            env_now = sct_pkg::ENV_FULL;
        env_now = (env_now > {6'd0, t.decay_step}) ? env_now - {6'd0, t.decay_step} : 16'd0;
        if (t.note_active)
        begin
            if (!pwm_down)
            begin
                pwm_now = pwm_now + sct_pkg::PWM_STEP;
                pwm_down = pwm_now > sct_pkg::PWM_TOP;
            end
            else
            begin
                pwm_now = pwm_now - sct_pkg::PWM_STEP;
                pwm_down = pwm_now > sct_pkg::PWM_BOTTOM;
            end
        end
        r.pitch_increment = pitch_now;
        r.cutoff_cv = 12'(env_now >> sct_pkg::CV_SHIFT);
        r.pwm_level = pwm_now;
        return r;
    endfunction

    task automatic queue_tick(input logic [15:0] target, input logic [15:0] glide,
                              input logic key, input logic note, input logic [9:0] decay);
        sct_pkg::item_t t;
        t.target_increment = target;
        t.glide_step = glide;
        t.key_pressed = key;
        t.note_active = note;
        t.decay_step = decay;
        pending_ticks.push_back(t);
    endtask

    // note phrases: key press on the first tick, steady glide and decay per phrase
    task automatic queue_phrases(input int count);
        int             n;
        int             len;
        int             sel;
        logic [15:0]    target;
        logic [15:0]    glide;
        logic [9:0]     decay;
        logic [63:0]    noise_bits;
        sct_pkg::item_t noise;
        n = 0;
        while (n < count)
        begin
            sel = $urandom_range(0, 9);
            target = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF : 16'($urandom);
            sel = $urandom_range(0, 9);
            if (sel == 0)
                glide = 16'd0;
            else if (sel == 1)
                glide = 16'hFFFF;
            else if (sel < 6)
                glide = 16'($urandom_range(0, 255));
            else if (sel < 8)
                glide = 16'($urandom_range(256, 4095));
            else
                glide = 16'($urandom);
            sel = $urandom_range(0, 9);
            if (sel == 0)
                decay = 10'd0;
            else if (sel == 1)
                decay = 10'd1023;
            else if (sel < 5)
                decay = 10'($urandom_range(1, 63));
            else
                decay = 10'($urandom_range(64, 1023));
            len = $urandom_range(1, 120);
            for (int i = 0; i < len && n < count; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    noise_bits = {$urandom, $urandom};
                    noise = noise_bits[$bits(sct_pkg::item_t)-1:0];
                    pending_ticks.push_back(noise);
                end
                else
                begin
                    if ($urandom_range(0, 19) == 0)
                        target = 16'($urandom);
                    queue_tick(target, glide, i == 0, $urandom_range(0, 49) != 0, decay);
                end
                n++;
            end
        end
    endtask

    task automatic drain;
        while (pending_ticks.size() != 0 || item_valid || expected_ticks.size() != 0)
            @(negedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            tick_in <= '0;
            pitch_now = '0;
            env_now = sct_pkg::ENV_FULL;
            pwm_now = '0;
            pwm_down = 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
                expected_ticks.push_back(advance_voice(tick_in));
            if (!item_valid || !item_stall)
            begin
                if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    tick_in <= pending_ticks.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        sct_pkg::result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_ticks.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    if (tick_out.pitch_increment !== want.pitch_increment)
                    begin
                        $error("pitch_increment expected %0d got %0d",
                               want.pitch_increment, tick_out.pitch_increment);
                        mismatches++;
                    end
                    if (tick_out.cutoff_cv !== want.cutoff_cv)
                    begin
                        $error("cutoff_cv expected %0d got %0d",
                               want.cutoff_cv, tick_out.cutoff_cv);
                        mismatches++;
                    end
                    if (tick_out.pwm_level !== want.pwm_level)
                    begin
                        $error("pwm_level expected %0d got %0d",
                               want.pwm_level, tick_out.pwm_level);
                        mismatches++;
                    end
                end
            end
            // long hold-off lets the block fill and back-pressure the sender
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if ((results_seen == 300 || results_seen == 1200)
                     && results_seen != last_hold_mark)
            begin
                last_hold_mark = results_seen;
                hold_left = HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 83;
        queue_tick(16'hFFFF, 16'd0,    1'b0, 1'b0, 10'd0);
        queue_tick(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 10'd1023);
        queue_tick(16'd0,    16'd1,    1'b0, 1'b1, 10'd512);
        queue_tick(16'd0,    16'hFFFF, 1'b0, 1'b0, 10'd1);
        queue_tick(16'd40000, 16'd15000, 1'b0, 1'b1, 10'd1000);
        queue_tick(16'd40000, 16'd15000, 1'b0, 1'b1, 10'd1000);
        queue_tick(16'd40000, 16'd15000, 1'b0, 1'b0, 10'd1000);
        queue_tick(16'd39990, 16'd5,     1'b1, 1'b1, 10'd0);
        queue_tick(16'd39990, 16'hFFFF,  1'b0, 1'b0, 10'd1023);
        queue_tick(16'h5555, 16'hAAAA,   1'b1, 1'b0, 10'h2AA);
        queue_tick(16'hAAAA, 16'h5555,   1'b0, 1'b1, 10'h155);
        queue_tick(16'd12345, 16'd12345, 1'b0, 1'b1, 10'd1023);
        queue_tick(16'd0,    16'd12345,  1'b0, 1'b1, 10'd1023);
        queue_tick(16'd1,    16'd0,      1'b1, 1'b1, 10'd1);
        queue_phrases(PHRASE_TICKS);
        drain();

        send_idle_pct = 83;
        recv_idle_pct = 26;
        queue_phrases(PHRASE_TICKS);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_phrases(PHRASE_TICKS);
        drain();

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> synth_control_tick.f
+incdir+rtl
rtl/sct_pkg.sv
rtl/sct_core.sv
rtl/synth_control_tick.sv
tb/sv/testbench.sv
